@@ sv/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg: shared definitions for the linear-probe hash table
// Request and response codes, field widths and the remainder step size used
// by the hash table and its channel interfaces.
// ----------------------------------------------------------------------------
package lpht_pkg;

	// Field widths of the two channels.
	localparam int REQ_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;

	// The remainder unit consumes this many magnitude bits per cycle.
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = VALUE_W / DIGIT_W;
	localparam int DIGIT_CW   = $clog2(NUM_DIGITS);

	typedef logic [REQ_W-1:0]    req_type_t;
	typedef logic [VALUE_W-1:0]  value_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [SLOT_W-1:0]   slot_t;

	// Request codes.
	localparam req_type_t REQ_INSERT = 2'd0;
	localparam req_type_t REQ_SEARCH = 2'd1;
	localparam req_type_t REQ_DELETE = 2'd2;
	localparam req_type_t REQ_UNUSED = 2'd3;

	// Response status codes.
	localparam status_t ST_INSERTED  = 3'd0;
	localparam status_t ST_FULL      = 3'd1;
	localparam status_t ST_FOUND     = 3'd2;
	localparam status_t ST_NOT_FOUND = 3'd3;
	localparam status_t ST_DELETED   = 3'd4;

endpackage

@@ sv/lpht_req_if.sv @@
// ----------------------------------------------------------------------------
// lpht_req_if: request channel of the hash table
// Carries one request item (operation code and signed value) with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpht_req_if;

	logic               valid;
	logic               ready;
	lpht_pkg::req_type_t req_type;
	lpht_pkg::value_t    value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink   (input valid, input req_type, input value, output ready);

endinterface

@@ sv/lpht_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lpht_rsp_if: response channel of the hash table
// Carries one response item (status and slot index) with a valid/ready
// handshake.
// ----------------------------------------------------------------------------
interface lpht_rsp_if;

	logic              valid;
	logic              ready;
	lpht_pkg::status_t status;
	lpht_pkg::slot_t   slot;

	modport source (output valid, output status, output slot, input ready);
	modport sink   (input valid, input status, input slot, output ready);

endinterface

@@ sv/linear_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table: linear-probing hash table with two columns
// Inserts, searches for or deletes signed values. Non-negative values live in
// column 0 and negative values in column 1; the home slot is the magnitude
// modulo NUM_SLOTS and probing wraps through the whole column.
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  req_type[1:0], value[31:0] (signed)
//   rsp      out  valid/ready  status[2:0], slot[3:0]
//
// A request first passes through the remainder unit (four magnitude bits per
// cycle), then through the probe loop, one slot compare per cycle through the
// slot RAM's read port.
// The block takes one request at a time; req.ready is high only when idle.
// A finished response waits in the output register while the next request is
// already accepted and worked on.
// Reset clears all slots at once through per-entry valid flags.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
	parameter int NUM_SLOTS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	lpht_req_if.sink    req,
	lpht_rsp_if.source  rsp
);

	localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int DEPTH = 2 * NUM_SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = SW + lpht_pkg::DIGIT_W;
	localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

	// Sequencer states.
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_MOD    = 2'd1;
	localparam logic [1:0] S_PROBE  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0]                    state_q;
	lpht_pkg::req_type_t           req_q;
	lpht_pkg::value_t              val_q;
	lpht_pkg::value_t              mag_q;
	logic                          col_q;
	logic [lpht_pkg::DIGIT_CW-1:0] dig_q;
	logic [SW-1:0]                 rem_q;
	logic [SW-1:0]                 rem_nxt;
	logic [SW-1:0]                 s_iss_q;
	logic [SW-1:0]                 s_cmp_q;
	logic [SW-1:0]                 n_q;
	logic                          cmp_vld_q;
	logic                          vbit_s1;
	logic [DEPTH-1:0]              vld_q;
	lpht_pkg::status_t             res_status_q;
	logic [SW-1:0]                 res_slot_q;
	logic                          rsp_vld_q;
	lpht_pkg::status_t             rsp_status_q;
	lpht_pkg::slot_t               rsp_slot_q;

	logic                          req_fire;
	logic                          out_free;
	logic                          neg_in;
	lpht_pkg::value_t              mag_in;
	logic [AW-1:0]                 raddr;
	logic [AW-1:0]                 waddr;
	logic                          ram_re;
	logic                          ram_we;
	lpht_pkg::value_t              rdata;
	lpht_pkg::value_t              entry;
	lpht_pkg::value_t              target;
	logic                          hit;

	// Column-relative slot to flat RAM address.
	function automatic logic [AW-1:0] slot_addr(input logic col, input logic [SW-1:0] s);
		logic [AW-1:0] a;
		a = AW'(s);
		if (col) begin
			a = a + AW'(NUM_SLOTS);
		end
		return a;
	endfunction

	// Next slot in probe order, wrapping at the end of the column.
	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + SW'(1);
	endfunction

	assign req_fire  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !rsp_vld_q || rsp.ready;
	assign neg_in    = req.value[lpht_pkg::VALUE_W-1];
	assign mag_in    = neg_in ? (lpht_pkg::VALUE_W'(0) - req.value) : req.value;

	// Remainder step: shift in one digit, then restoring subtracts of N*8..N.
	always_comb begin
		logic [TW-1:0] t;
		t = {rem_q, mag_q[lpht_pkg::VALUE_W-1 -: lpht_pkg::DIGIT_W]};
		for (int k = lpht_pkg::DIGIT_W - 1; k >= 0; k--) begin
			if (t >= (TW'(NUM_SLOTS) << k)) begin
				t = t - (TW'(NUM_SLOTS) << k);
			end
		end
		rem_nxt = t[SW-1:0];
	end

	// Slot RAM access: one read issued per probe cycle, compared in the next cycle.
	assign ram_re = (state_q == S_PROBE);
	assign raddr  = slot_addr(col_q, s_iss_q);
	assign waddr  = slot_addr(col_q, s_cmp_q);
	assign entry  = vbit_s1 ? rdata : '0;
	assign target = (req_q == lpht_pkg::REQ_INSERT) ? '0 : val_q;
	assign hit    = (state_q == S_PROBE) && cmp_vld_q && (entry == target);
	assign ram_we = hit && (req_q == lpht_pkg::REQ_INSERT);

	lpht_ram #(
		.WIDTH (lpht_pkg::VALUE_W),
		.DEPTH (DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (val_q),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Request payload capture.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req.req_type;
			val_q <= req.value;
			col_q <= neg_in;
		end
	end

	// Valid flag read alongside the RAM read.
	always_ff @(posedge clk) begin
		if (ram_re) begin
			vbit_s1 <= vld_q[raddr];
		end
	end

	// Sequencer, remainder unit and probe loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mag_q        <= '0;
			dig_q        <= '0;
			rem_q        <= '0;
			s_iss_q      <= '0;
			s_cmp_q      <= '0;
			n_q          <= '0;
			cmp_vld_q    <= 1'b0;
			vld_q        <= '0;
			res_status_q <= lpht_pkg::ST_NOT_FOUND;
			res_slot_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						mag_q   <= mag_in;
						dig_q   <= '0;
						rem_q   <= '0;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					rem_q <= rem_nxt;
					mag_q <= mag_q << lpht_pkg::DIGIT_W;
					dig_q <= dig_q + lpht_pkg::DIGIT_CW'(1);
					if (dig_q == lpht_pkg::DIGIT_CW'(lpht_pkg::NUM_DIGITS - 1)) begin
						s_iss_q   <= rem_nxt;
						n_q       <= '0;
						cmp_vld_q <= 1'b0;
						if (req_q == lpht_pkg::REQ_UNUSED) begin
							res_status_q <= lpht_pkg::ST_NOT_FOUND;
							res_slot_q   <= '0;
							state_q      <= S_FINISH;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					s_iss_q   <= next_slot(s_iss_q);
					s_cmp_q   <= s_iss_q;
					cmp_vld_q <= 1'b1;
					if (hit) begin
						res_slot_q <= s_cmp_q;
						state_q    <= S_FINISH;
						unique case (req_q)
							lpht_pkg::REQ_INSERT: begin
								vld_q[waddr] <= 1'b1;
								res_status_q <= lpht_pkg::ST_INSERTED;
							end
							lpht_pkg::REQ_DELETE: begin
								vld_q[waddr] <= 1'b0;
								res_status_q <= lpht_pkg::ST_DELETED;
							end
							default: begin
								res_status_q <= lpht_pkg::ST_FOUND;
							end
						endcase
					end else if (cmp_vld_q) begin
						n_q <= n_q + SW'(1);
						if (n_q == LAST_SLOT) begin
							res_slot_q   <= '0;
							res_status_q <= (req_q == lpht_pkg::REQ_INSERT) ?
								lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
							state_q      <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: loaded when a result is ready and the previous one left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_slot_q   <= lpht_pkg::SLOT_W'(res_slot_q);
		end
	end

	assign rsp.valid  = rsp_vld_q;
	assign rsp.status = rsp_status_q;
	assign rsp.slot   = rsp_slot_q;

	// The remainder and probe slots always stay inside the column.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q <= LAST_SLOT) && (s_iss_q <= LAST_SLOT) && (s_cmp_q <= LAST_SLOT))
		else $error("slot index or remainder out of range");

	// The probe never compares more than one full column.
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE) |-> (n_q <= LAST_SLOT))
		else $error("probe ran past the column");

	// The slot RAM is written only on an insert hit during probing.
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_PROBE && cmp_vld_q && req_q == lpht_pkg::REQ_INSERT))
		else $error("unexpected slot write");

	// A finished result reaches the output in the next cycle.
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_free) |=> (rsp.valid && state_q == S_IDLE))
		else $error("result not presented");

	// An accepted item starts the remainder unit.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == S_MOD && dig_q == '0 && rem_q == '0))
		else $error("request did not start");

endmodule

@@ sv/lpht_ram.sv @@
// ----------------------------------------------------------------------------
// lpht_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
